>>> rtl/core/contiguous_block_allocator_unit_macros.svh
// Assertion macros used by the checker file of the allocator.
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define CBAU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked during reset.
`define CBAU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/cbau_pkg.sv
package cbau_pkg;

    localparam int MAP_BLOCKS_DEF = 64;
    localparam int SIZE_W         = 9;
    localparam int CFG_W          = 7;
    localparam int START_W        = 6;
    localparam int FREE_KB_W      = 9;
    localparam int KB_SHIFT       = 2;
    localparam int NEED_W         = SIZE_W - KB_SHIFT;
    localparam int ROOT_BLOCK     = 0;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_en;
        logic load;
        logic scan_en;
        logic mark_en;
        logic result_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic lim_zero;
        logic scan_last;
        logic mark_needed;
        logic mark_last;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/core/cbau_req_if.sv
interface cbau_req_if import cbau_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] size_kb;

    modport source (output valid, output size_kb, input ready);
    modport sink   (input valid, input size_kb, output ready);
endinterface

>>> rtl/core/cbau_rsp_if.sv
interface cbau_rsp_if import cbau_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 granted;
    logic [START_W-1:0]   start_block;
    logic [FREE_KB_W-1:0] free_kb;

    modport source (output valid, output granted, output start_block, output free_kb,
                    input ready);
    modport sink   (input valid, input granted, input start_block, input free_kb,
                    output ready);
endinterface

>>> rtl/core/cbau_ram.sv
module cbau_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/cbau_datapath.sv
module cbau_datapath import cbau_pkg::*; #(
    parameter int MAP_BLOCKS = MAP_BLOCKS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [SIZE_W-1:0]    i_size_kb,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_W-1:0]     i_cfg_wr_data,
    input  logic                 i_rsp_ready,
    output logic                 o_rsp_valid,
    output logic                 o_granted,
    output logic [START_W-1:0]   o_start_block,
    output logic [FREE_KB_W-1:0] o_free_kb
);

    localparam int IW = (MAP_BLOCKS > 1) ? $clog2(MAP_BLOCKS) : 1;
    localparam int CW = $clog2(MAP_BLOCKS + 1);
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;

    logic [CFG_W-1:0]     r_cfg;
    logic [NEED_W-1:0]    r_need;
    logic [IW-1:0]        r_clr_ptr;
    logic [IW-1:0]        r_rd_addr;
    logic                 r_rd_vld;
    logic [IW-1:0]        r_rd_idx;
    logic [CW-1:0]        r_run;
    logic [IW-1:0]        r_cand;
    logic                 r_found;
    logic [IW-1:0]        r_start;
    logic [CW-1:0]        r_cnt;
    logic [IW-1:0]        r_mark_ptr;
    logic [NEED_W-1:0]    r_mark_cnt;
    logic                 r_out_vld;
    logic                 r_granted;
    logic [START_W-1:0]   r_start_block;
    logic [FREE_KB_W-1:0] r_free_kb;

    logic [CW-1:0]        lim;
    logic                 rd_free;
    logic                 we;
    logic [IW-1:0]        waddr;
    logic                 wdata;
    logic [CW-1:0]        n_run;
    logic [IW-1:0]        n_cand;
    logic                 hit;
    logic [CW-1:0]        free_after;
    logic [CW+1:0]        free_kb_full;

    // Blocks above the configured count, or above the map, are never looked at.
    always_comb begin
        if (LW'(r_cfg) > LW'(MAP_BLOCKS)) begin
            lim = CW'(MAP_BLOCKS);
        end else begin
            lim = CW'(r_cfg);
        end
    end

    always_comb begin
        we    = i_cmd.clear_en | i_cmd.mark_en;
        waddr = i_cmd.clear_en ? r_clr_ptr : r_mark_ptr;
        wdata = i_cmd.clear_en ? (r_clr_ptr != IW'(ROOT_BLOCK)) : 1'b0;
    end

    cbau_ram #(
        .WIDTH (1),
        .DEPTH (MAP_BLOCKS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.scan_en),
        .i_raddr (r_rd_addr),
        .o_rdata (rd_free)
    );

    // Run tracking for the bit that comes back from the map this cycle.
    always_comb begin
        n_run  = r_run + CW'(1);
        n_cand = (r_run == '0) ? r_rd_idx : r_cand;
        hit    = !r_found && (LW'(n_run) == LW'(r_need));
    end

    always_comb begin
        free_after   = r_cnt - ((r_found && r_need != '0) ? CW'(r_need) : CW'(0));
        free_kb_full = {free_after, 2'b00};
    end

    always_comb begin
        o_sts.clear_done  = (r_clr_ptr == IW'(MAP_BLOCKS - 1));
        o_sts.lim_zero    = (lim == '0);
        o_sts.scan_last   = (CW'(r_rd_addr) == lim - CW'(1));
        o_sts.mark_needed = r_found && (r_need != '0);
        o_sts.mark_last   = (r_mark_cnt == r_need - NEED_W'(1));
        o_sts.out_free    = !r_out_vld || i_rsp_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= CFG_RESET;
            r_clr_ptr  <= '0;
            r_rd_addr  <= '0;
            r_rd_vld   <= 1'b0;
            r_run      <= '0;
            r_found    <= 1'b0;
            r_cnt      <= '0;
            r_mark_cnt <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (i_cmd.clear_en) begin
                r_clr_ptr <= r_clr_ptr + IW'(1);
            end
            r_rd_vld <= i_cmd.scan_en;
            if (i_cmd.load) begin
                r_rd_addr  <= '0;
                r_run      <= '0;
                r_found    <= (i_size_kb[SIZE_W-1:KB_SHIFT] == '0);
                r_cnt      <= '0;
                r_mark_cnt <= '0;
            end else begin
                if (i_cmd.scan_en) begin
                    r_rd_addr <= r_rd_addr + IW'(1);
                end
                if (r_rd_vld) begin
                    if (rd_free) begin
                        r_run <= n_run;
                        r_cnt <= r_cnt + CW'(1);
                        if (hit) begin
                            r_found <= 1'b1;
                        end
                    end else begin
                        r_run <= '0;
                    end
                end
                if (i_cmd.mark_en) begin
                    r_mark_cnt <= r_mark_cnt + NEED_W'(1);
                end
            end
            if (i_cmd.result_load) begin
                r_out_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_rd_addr;
        if (i_cmd.load) begin
            r_need  <= i_size_kb[SIZE_W-1:KB_SHIFT];
            r_start <= '0;
        end else begin
            if (r_rd_vld && rd_free) begin
                r_cand <= n_cand;
                if (hit) begin
                    r_start    <= n_cand;
                    r_mark_ptr <= n_cand;
                end
            end
            if (i_cmd.mark_en) begin
                r_mark_ptr <= r_mark_ptr + IW'(1);
            end
        end
        if (i_cmd.result_load) begin
            r_granted     <= r_found;
            r_start_block <= START_W'(r_start);
            r_free_kb     <= FREE_KB_W'(free_kb_full);
        end
    end

    assign o_rsp_valid   = r_out_vld;
    assign o_granted     = r_granted;
    assign o_start_block = r_start_block;
    assign o_free_kb     = r_free_kb;

endmodule

>>> rtl/core/cbau_ctrl.sv
module cbau_ctrl import cbau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_MARK,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_req_ready;

    always_comb begin
        o_cmd             = '0;
        o_cmd.clear_en    = (r_state == S_CLEAR);
        o_cmd.load        = (r_state == S_IDLE) && i_req_valid;
        o_cmd.scan_en     = (r_state == S_SCAN);
        o_cmd.mark_en     = (r_state == S_MARK);
        o_cmd.result_load = (r_state == S_FINISH) && i_sts.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_req_ready <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.clear_done) begin
                        r_state     <= S_IDLE;
                        r_req_ready <= 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req_ready <= 1'b0;
                        r_state     <= i_sts.lim_zero ? S_FINISH : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_sts.scan_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_state <= i_sts.mark_needed ? S_MARK : S_FINISH;
                end
                S_MARK: begin
                    if (i_sts.mark_last) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (i_sts.out_free) begin
                        r_state     <= S_IDLE;
                        r_req_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_req_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_req_ready = r_req_ready;

endmodule

>>> rtl/core/contiguous_block_allocator_unit.sv
// A request transaction passes through the map scan, one bit per cycle up to the usable block
// count L, the drain and decide states, the marking of the N blocks granted (zero on failure or
// an empty request) and the loading of the response register; with L = 0 it goes straight to
// the response register. The next request transaction is accepted only after that load, which
// waits while the response register is still occupied. Reset is synchronous and active low;
// afterwards the map is cleared, with no request transaction accepted.
module contiguous_block_allocator_unit import cbau_pkg::*; #(
    parameter int MAP_BLOCKS = MAP_BLOCKS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cbau_req_if.sink         i_req,
    cbau_rsp_if.source       o_rsp,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data
);

    // The free map lives in a one-bit-wide RAM inside the datapath. A request first
    // scans the map from block 0 up to the usable limit, one bit per cycle, tracking
    // the current run of free blocks and the total free count. The first run that
    // reaches the requested length is remembered (first fit); later bits are still
    // read so that the free count covers the whole usable range.
    //
    // When a run was found, the controller then walks through it and clears one map
    // bit per cycle. The response carries the grant flag, the start block and the
    // free space after the request, which is the scanned free count less the blocks
    // just taken, times four kilobytes.
    //
    // The response sits in an output register, so the controller can go back to idle
    // and accept the next request transaction while the previous response waits.
    // A finished request only stalls if that register is still occupied.

    t_cmd cmd;
    t_sts sts;

    cbau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cbau_datapath #(
        .MAP_BLOCKS (MAP_BLOCKS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_size_kb     (i_req.size_kb),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_rsp_ready   (o_rsp.ready),
        .o_rsp_valid   (o_rsp.valid),
        .o_granted     (o_rsp.granted),
        .o_start_block (o_rsp.start_block),
        .o_free_kb     (o_rsp.free_kb)
    );

endmodule

>>> rtl/core/cbau_checker.sv
`include "contiguous_block_allocator_unit_macros.svh"

module cbau_checker import cbau_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  logic                 i_rsp_valid,
    input  logic                 i_rsp_ready,
    input  logic                 i_granted,
    input  logic [START_W-1:0]   i_start_block,
    input  logic [FREE_KB_W-1:0] i_free_kb
);

    // A response that is not taken stays offered.
    `CBAU_ASSERT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid, "response dropped while stalled")

    // A refused request reports start block zero.
    `CBAU_ASSERT(a_fail_start, i_clk, i_rst_n, i_rsp_valid && !i_granted |-> i_start_block == '0, "failed request with nonzero start block")

    // Free space is counted in whole blocks of four kilobytes.
    `CBAU_ASSERT(a_free_align, i_clk, i_rst_n, i_rsp_valid |-> i_free_kb[1:0] == 2'b00, "free space not a multiple of four")

    // Reset leaves neither side busy: the map clearing pass follows.
    `CBAU_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !i_req_ready && !i_rsp_valid, "handshake active after reset")

endmodule

bind contiguous_block_allocator_unit cbau_checker u_cbau_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_granted     (o_rsp.granted),
    .i_start_block (o_rsp.start_block),
    .i_free_kb     (o_rsp.free_kb)
);

>>> sim/contiguous_block_allocator_unit_tb.sv
`timescale 1ns / 100ps

module contiguous_block_allocator_unit_tb;
    import cbau_pkg::*;

    localparam int     CLK_PERIOD_NS     = 2;
    localparam int     RESET_CYCLES      = 4;
    localparam int     MAX_IDLE          = 7;
    localparam int     IDLE_WINDOW       = 32;
    // The receiver stops taking responses for this long once, while the sender keeps
    // offering requests, so the allocator has to hold its input off.
    localparam int     LONG_HOLD_CYCLES  = 400;
    localparam int     LONG_HOLD_AT_RSP  = 60;
    // The drain wait outlasts the slowest request: a full map scan plus marking every block.
    localparam int     DRAIN_CYCLES      = 2 * MAP_BLOCKS_DEF + 32;
    localparam int     ITEMS_PER_PHASE   = 100;
    localparam longint WATCHDOG_NS       = 1_500_000;

    // One response transaction as it appears on the response channel.
    typedef struct packed {
        logic                 granted;
        logic [START_W-1:0]   start_block;
        logic [FREE_KB_W-1:0] free_kb;
    } t_alloc_rsp;

    typedef enum logic {
        ROW_REQUEST,
        ROW_SET_LIMIT
    } t_row_kind;

    // A directed row either issues a request of value KB or writes value as the new
    // block limit. When typed is set, rsp holds the response written out by hand;
    // otherwise the response comes from the allocation predictor below.
    typedef struct packed {
        t_row_kind         kind;
        logic [SIZE_W-1:0] value;
        logic              typed;
        t_alloc_rsp        rsp;
    } t_directed_row;

    localparam t_alloc_rsp FROM_PREDICTOR = '0;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CFG_W-1:0]  cfg_wr_data;

    cbau_req_if req_if ();
    cbau_rsp_if rsp_if ();

    contiguous_block_allocator_unit i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_if),
        .o_rsp         (rsp_if),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // Shadow copy of the allocator state. A set bit in block_free marks a free block.
    logic [MAP_BLOCKS_DEF-1:0] block_free;
    logic [CFG_W-1:0]          block_limit;

    // Responses still owed by the allocator, oldest first.
    t_alloc_rsp owed_rsp_q[$];
    int         error_count;
    int         rsp_count;
    bit         quiet_tx;

    // Directed opening. It starts from the state right after reset (only the root
    // directory block is taken), covers empty and oversized requests, a zero limit, a
    // limit that leaves nothing free, a saturating limit, runs that end exactly at the
    // limit, and limit changes made after blocks have already been handed out.
    t_directed_row directed_rows [22] = '{
        '{ROW_REQUEST,   9'd0,   1'b1, '{1'b1, 6'd0, 9'd252}},
        '{ROW_REQUEST,   9'd3,   1'b1, '{1'b1, 6'd0, 9'd252}},
        '{ROW_REQUEST,   9'd511, 1'b1, '{1'b0, 6'd0, 9'd252}},
        '{ROW_REQUEST,   9'd256, 1'b1, '{1'b0, 6'd0, 9'd252}},
        '{ROW_REQUEST,   9'd5,   1'b0, FROM_PREDICTOR},
        '{ROW_SET_LIMIT, 9'd0,   1'b0, FROM_PREDICTOR},
        '{ROW_REQUEST,   9'd4,   1'b1, '{1'b0, 6'd0, 9'd0}},
        '{ROW_REQUEST,   9'd0,   1'b1, '{1'b1, 6'd0, 9'd0}},
        '{ROW_SET_LIMIT, 9'd1,   1'b0, FROM_PREDICTOR},
        '{ROW_REQUEST,   9'd4,   1'b1, '{1'b0, 6'd0, 9'd0}},
        '{ROW_SET_LIMIT, 9'd3,   1'b0, FROM_PREDICTOR},
        '{ROW_REQUEST,   9'd4,   1'b0, FROM_PREDICTOR},
        '{ROW_REQUEST,   9'd4,   1'b1, '{1'b0, 6'd0, 9'd0}},
        '{ROW_SET_LIMIT, 9'd127, 1'b0, FROM_PREDICTOR},
        '{ROW_REQUEST,   9'd0,   1'b0, FROM_PREDICTOR},
        '{ROW_REQUEST,   9'd9,   1'b0, FROM_PREDICTOR},
        '{ROW_SET_LIMIT, 9'd10,  1'b0, FROM_PREDICTOR},
        '{ROW_REQUEST,   9'd20,  1'b0, FROM_PREDICTOR},
        '{ROW_REQUEST,   9'd24,  1'b1, '{1'b0, 6'd0, 9'd0}},
        '{ROW_SET_LIMIT, 9'd64,  1'b0, FROM_PREDICTOR},
        '{ROW_REQUEST,   9'd220, 1'b0, FROM_PREDICTOR},
        '{ROW_REQUEST,   9'd7,   1'b0, FROM_PREDICTOR}
    };

    // Block limit for each random phase. Blocks are never released, so the limits mostly
    // climb; the map fills up to each limit in turn and the last phases run on a full map.
    logic [CFG_W-1:0] phase_limits [7] = '{7'd0, 7'd1, 7'd16, 7'd24, 7'd40, 7'd127, 7'd64};

    // Limits above the map size behave as the map size.
    function automatic int usable_blocks();
        return (block_limit > MAP_BLOCKS_DEF) ? MAP_BLOCKS_DEF : int'(block_limit);
    endfunction

    function automatic logic [FREE_KB_W-1:0] free_space_kb();
        int count;
        count = 0;
        for (int b = 0; b < usable_blocks(); b++) begin
            if (block_free[b]) begin
                count++;
            end
        end
        return FREE_KB_W'(count << KB_SHIFT);
    endfunction

    // First-fit allocation on the shadow map. Returns the response the allocator owes
    // and marks the granted run as used.
    function automatic t_alloc_rsp predict_allocation(logic [SIZE_W-1:0] size_kb);
        int         need;
        int         limit;
        int         run;
        int         run_start;
        t_alloc_rsp rsp;
        need      = int'(size_kb >> KB_SHIFT);
        limit     = usable_blocks();
        run       = 0;
        run_start = 0;
        rsp       = '0;
        if (need == 0) begin
            // An empty request always succeeds and touches nothing.
            rsp.granted = 1'b1;
        end else begin
            for (int b = 0; b < limit && run < need; b++) begin
                if (block_free[b]) begin
                    if (run == 0) begin
                        run_start = b;
                    end
                    run++;
                end else begin
                    run = 0;
                end
            end
            if (run == need) begin
                for (int b = run_start; b < run_start + need; b++) begin
                    block_free[b] = 1'b0;
                end
                rsp.granted     = 1'b1;
                rsp.start_block = START_W'(run_start);
            end
        end
        rsp.free_kb = free_space_kb();
        return rsp;
    endfunction

    // Length of the run that starts at the lowest free block below the limit.
    function automatic int lowest_free_run();
        int run;
        run = 0;
        for (int b = 0; b < usable_blocks(); b++) begin
            if (block_free[b]) begin
                run++;
            end else if (run != 0) begin
                break;
            end
        end
        return run;
    endfunction

    // Mostly small requests, so the map fills over many transactions. Some requests ask
    // for exactly the lowest free run, which drives allocations right up to the limit
    // (and up to the last block of the map once the limit allows it). The rest spans the
    // whole field, which makes most of them fail.
    function automatic logic [SIZE_W-1:0] random_size(bit fill_run);
        int pick;
        int run;
        run  = lowest_free_run();
        pick = fill_run ? 0 : $urandom_range(0, 99);
        if (pick < 10 && run != 0) begin
            return SIZE_W'((run << KB_SHIFT) + $urandom_range(0, 3));
        end
        if (pick < 55) begin
            return SIZE_W'($urandom_range(0, 15));
        end
        if (pick < 70) begin
            return SIZE_W'($urandom_range(16, 63));
        end
        return SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1));
    endfunction

    // Offers one request and waits for its transaction. The expected response is booked
    // at acceptance, when the shadow map matches what the allocator will see. Valid stays
    // high after acceptance; it is either lowered here for a gap, lowered by the caller,
    // or reused at once for the next request, always by a single assignment per step.
    task automatic send_request(input logic [SIZE_W-1:0] size_kb, input logic typed,
                                input t_alloc_rsp typed_rsp);
        int         gap;
        t_alloc_rsp predicted;
        gap = quiet_tx ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.size_kb <= size_kb;
        do @(posedge clk); while (!req_if.ready);
        predicted = predict_allocation(size_kb);
        owed_rsp_q.push_back(typed ? typed_rsp : predicted);
    endtask

    // The limit is only written once every owed response has come back; every request
    // produces a response, so the allocator is idle by then.
    task automatic set_limit(input logic [CFG_W-1:0] value);
        req_if.valid <= 1'b0;
        while (owed_rsp_q.size() != 0) @(posedge clk);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        block_limit = value;
    endtask

    task automatic report_mismatch(input string field, input int expected, input int actual);
        error_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expected, actual);
    endtask

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD_NS / 2) clk = ~clk;
    end

    // Drives requests and limit writes: the directed table first, then the random phases.
    initial begin : stimulus
        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= '0;
        req_if.valid   <= 1'b0;
        req_if.size_kb <= '0;
        error_count    = 0;
        quiet_tx       = 1'b0;
        block_free     = '1;
        block_free[ROOT_BLOCK] = 1'b0;
        block_limit    = CFG_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // The allocator clears its map after reset and refuses requests meanwhile; the
        // first request simply waits for its handshake.
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_SET_LIMIT) begin
                set_limit(CFG_W'(directed_rows[r].value));
            end else begin
                send_request(directed_rows[r].value, directed_rows[r].typed,
                             directed_rows[r].rsp);
            end
        end

        // Each phase ends with a request for the whole lowest free run, so every phase
        // also fills its range right to the limit.
        foreach (phase_limits[p]) begin
            set_limit(phase_limits[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % IDLE_WINDOW == 0) begin
                    quiet_tx = ($urandom_range(0, 3) == 0);
                end
                send_request(random_size(n == ITEMS_PER_PHASE - 1), 1'b0, FROM_PREDICTOR);
            end
        end

        req_if.valid <= 1'b0;
        while (owed_rsp_q.size() != 0) @(posedge clk);
        // Any response that shows up now has no request behind it.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && owed_rsp_q.size() == 0) begin
            $display("[contiguous_block_allocator_unit] OK");
        end else begin
            $display("[contiguous_block_allocator_unit] ERROR");
        end
        $finish;
    end

    // Takes responses with random stalls and checks each one against the oldest owed
    // response. Stall windows alternate with stretches of back-to-back acceptance.
    initial begin : response_checker
        int         gap;
        bit         quiet_rx;
        t_alloc_rsp got;
        t_alloc_rsp want;
        rsp_if.ready <= 1'b0;
        rsp_count    = 0;
        quiet_rx     = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (rsp_count % IDLE_WINDOW == 0) begin
                quiet_rx = ($urandom_range(0, 3) == 0);
            end
            if (rsp_count == LONG_HOLD_AT_RSP) begin
                gap = LONG_HOLD_CYCLES;
            end else begin
                gap = quiet_rx ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (gap != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
            got.granted     = rsp_if.granted;
            got.start_block = rsp_if.start_block;
            got.free_kb     = rsp_if.free_kb;
            rsp_count++;
            if (owed_rsp_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected response, expected none, got %s %0d %s %0d %s %0d",
                         $time, "granted", got.granted, "start", got.start_block,
                         "free", got.free_kb);
            end else begin
                want = owed_rsp_q.pop_front();
                if (got.granted !== want.granted) begin
                    report_mismatch("granted", want.granted, got.granted);
                end
                if (got.start_block !== want.start_block) begin
                    report_mismatch("start_block", want.start_block, got.start_block);
                end
                if (got.free_kb !== want.free_kb) begin
                    report_mismatch("free_kb", want.free_kb, got.free_kb);
                end
            end
        end
    end

    // Ends a hung run. The fixed time is several times the slowest legal run: every
    // request at full scan and mark latency plus the longest gaps on both sides.
    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("[contiguous_block_allocator_unit] ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/cbau_pkg.sv
rtl/core/cbau_req_if.sv
rtl/core/cbau_rsp_if.sv
rtl/core/cbau_ram.sv
rtl/core/cbau_datapath.sv
rtl/core/cbau_ctrl.sv
rtl/core/contiguous_block_allocator_unit.sv
rtl/core/cbau_checker.sv
sim/contiguous_block_allocator_unit_tb.sv
